[hw/rtl/chcp_pkg.sv]
// shared types, constants and hash functions for the cuckoo hash block
package chcp_pkg;

  localparam int TABLE_SIZE  = 1024;
  localparam int KEY_WORDS   = 4;
  localparam int KICK_LIMIT  = 1024;
  localparam int IN_WORDS    = (KEY_WORDS < 4) ? KEY_WORDS : 4;
  localparam int NSLOTS      = 2 * TABLE_SIZE;
  localparam int SLOT_W      = $clog2(NSLOTS);
  localparam int HALF_W      = $clog2(TABLE_SIZE);
  localparam int KICK_W      = $clog2(KICK_LIMIT + 1);
  localparam int ENTRY_W     = 32 * KEY_WORDS + 32;

  localparam logic [2:0]  CFG_KEY_WORDS = 3'd0;
  localparam logic [2:0]  CFG_MISS_CODE = 3'd1;
  localparam logic [2:0]  CFG_HIT_CODE  = 3'd2;
  localparam logic [31:0] MISS_RST      = 32'd3153797;
  localparam logic [31:0] HIT_RST       = 32'd3153800;

  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_PROBE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] key_word0;
    logic [31:0] key_word1;
    logic [31:0] key_word2;
    logic [31:0] key_word3;
    logic [31:0] tuple_count;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] match_value;
    logic [31:0] count_out;
    logic        status;
  } out_item_t;

  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_HASHB, ST_RD1, ST_CMP1, ST_RD2, ST_CMP2,
    ST_KHASH, ST_KHASHB, ST_KRD, ST_KSWAP, ST_DONE
  } state_t;

  function automatic logic [HALF_W-1:0] hash_a(key_t k, logic [2:0] n);
    logic [31:0] h;
    h = '0;
    for (int i = 0; i < IN_WORDS; i++)
      if (i < n) h = (h << 1) + k[i];
    return h[HALF_W-1:0];
  endfunction

  function automatic logic [31:0] hb_term(logic [31:0] w);
    return w ^ (w >> 3);
  endfunction

  function automatic logic [HALF_W-1:0] hb_fold(logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 3);
    return t[HALF_W-1:0];
  endfunction

endpackage

[hw/rtl/chcp_ram.sv]
// generic single-port ram with registered read
module chcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[hw/rtl/chcp_hashb.sv]
// second hash, one key word per cycle through one multiplier
module chcp_hashb import chcp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  key_t              key,
  input  logic [2:0]        n,
  output logic              done,
  output logic [HALF_W-1:0] slot
);
  logic [31:0] h_r, h_nxt;
  logic [2:0]  i_r, i_nxt;
  logic        busy_r, busy_nxt;
  logic [1:0]  idx;
  logic [63:0] prod;

  assign idx  = i_r[1:0];
  assign prod = 64'(h_r) * 64'(hb_term(key[idx]));
  assign slot = hb_fold(h_r);

  always_comb begin
    h_nxt = h_r; i_nxt = i_r; busy_nxt = busy_r; done = 1'b0;
    if (start) begin
      h_nxt = 32'd1; i_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (i_r >= n) begin
        done = 1'b1; busy_nxt = 1'b0;
      end else begin
        h_nxt = prod[31:0]; i_nxt = i_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    h_r <= h_nxt;
    i_r <= i_nxt;
  end
endmodule

[hw/rtl/cuckoo_hash_count_and_probe.sv]
// top level of the two-choice cuckoo hash with count aggregation and probes
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | in_item_t
//  out_    | output    | out_valid/stall  | out_item_t
//  cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// one transaction at a time; the second hash takes one key word per cycle through
// its multiplier. after accept both hashes run, then the first slot is read and
// compared and a hit hands its result over; a second-slot lookup adds a read and
// compare, a build miss places the key in its first slot by a read and swap, and
// each displacement rehashes the evicted key for the other table before its own
// read and swap, up to the kick limit. after reset a clearing pass zeroes all
// NSLOTS (2048) valid bits, taking no input; the result has its own register, so
// the next transaction runs while it waits; a stalled result holds the block in done
module cuckoo_hash_count_and_probe import chcp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  // config registers
  logic [2:0]  kwu_r;
  logic [31:0] miss_r, hit_r;
  logic [2:0]  n;

  always_comb begin
    n = kwu_r;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(IN_WORDS)) n = 3'(IN_WORDS);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kwu_r <= 3'd1; miss_r <= MISS_RST; hit_r <= HIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY_WORDS: kwu_r  <= cfg_data[2:0];
        CFG_MISS_CODE: miss_r <= cfg_data;
        CFG_HIT_CODE:  hit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t st_r, st_nxt;

  // item and entry in hand
  logic        func_r;
  logic [31:0] cnt_r;
  key_t        hk_r, hk_nxt;
  logic [31:0] hc_r, hc_nxt;
  logic        first_r, first_nxt;
  logic [KICK_W-1:0] kick_r, kick_nxt;
  logic [HALF_W-1:0] sa_r, sa_nxt, sb_r, sb_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic        ovalid_r, ovalid_nxt;
  out_item_t   out_r, out_nxt;
  out_item_t   res_r, res_nxt;

  // table memories: valid bit and packed entry
  logic [SLOT_W-1:0]  addr;
  logic               v_we, v_wd, v_rd;
  logic               e_we;
  logic [ENTRY_W-1:0] e_wd, e_rd;
  key_t               rd_key;
  logic [31:0]        rd_cnt;

  chcp_ram #(.WIDTH(1), .DEPTH(NSLOTS)) u_valid (
    .clk(clk), .we(v_we), .addr(addr), .wdata(v_wd), .rdata(v_rd));
  chcp_ram #(.WIDTH(ENTRY_W), .DEPTH(NSLOTS)) u_entry (
    .clk(clk), .we(e_we), .addr(addr), .wdata(e_wd), .rdata(e_rd));

  assign rd_key = e_rd[ENTRY_W-1:32];
  assign rd_cnt = e_rd[31:0];

  // hash b unit
  logic hb_start, hb_done;
  logic [HALF_W-1:0] hb_slot;
  chcp_hashb u_hashb (
    .clk(clk), .rst_n(rst_n), .start(hb_start), .key(hk_r), .n(n),
    .done(hb_done), .slot(hb_slot));

  // key compare over the first n words
  logic key_eq;
  always_comb begin
    key_eq = 1'b1;
    for (int i = 0; i < IN_WORDS; i++)
      if (i < n && rd_key[i] != hk_r[i]) key_eq = 1'b0;
  end

  // masked incoming key
  key_t in_key;
  always_comb begin
    in_key = '0;
    in_key[0] = in_data.key_word0;
    if (IN_WORDS > 1 && n > 3'd1) in_key[1] = in_data.key_word1;
    if (IN_WORDS > 2 && n > 3'd2) in_key[2] = in_data.key_word2;
    if (IN_WORDS > 3 && n > 3'd3) in_key[3] = in_data.key_word3;
  end

  logic [32:0] sum;
  assign sum = {1'b0, rd_cnt} + {1'b0, cnt_r};

  // result register is free or being emptied this cycle
  logic res_free;
  assign res_free = !ovalid_r || !out_stall;

  logic accept;
  assign in_stall = (st_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR:  if (clr_r == SLOT_W'(NSLOTS - 1)) st_nxt = ST_IDLE;
      ST_IDLE:   if (accept) st_nxt = ST_HASHB;
      ST_HASHB:  if (hb_done) st_nxt = ST_RD1;
      ST_RD1:    st_nxt = ST_CMP1;
      ST_CMP1:   if (v_rd && key_eq) st_nxt = ST_DONE;
                 else st_nxt = ST_RD2;
      ST_RD2:    st_nxt = ST_CMP2;
      ST_CMP2:   if ((v_rd && key_eq) || func_r == FUNC_PROBE) st_nxt = ST_DONE;
                 else st_nxt = ST_KRD;
      ST_KHASH:  if (kick_r == KICK_W'(KICK_LIMIT)) st_nxt = ST_DONE;
                 else if (first_r) st_nxt = ST_KRD;
                 else st_nxt = ST_KHASHB;
      ST_KHASHB: if (hb_done) st_nxt = ST_KRD;
      ST_KRD:    st_nxt = ST_KSWAP;
      ST_KSWAP:  if (!v_rd) st_nxt = ST_DONE;
                 else st_nxt = ST_KHASH;
      ST_DONE:   if (res_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    hk_nxt = hk_r; hc_nxt = hc_r; first_nxt = first_r; kick_nxt = kick_r;
    sa_nxt = sa_r; sb_nxt = sb_r; clr_nxt = clr_r;
    ovalid_nxt = ovalid_r; out_nxt = out_r; res_nxt = res_r;
    hb_start = 1'b0;
    v_we = 1'b0; v_wd = 1'b1; e_we = 1'b0;
    e_wd = {hk_r, hc_r};
    addr = {1'b0, sa_r};
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    case (st_r)
      ST_CLEAR: begin
        addr = clr_r; v_we = 1'b1; v_wd = 1'b0; clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: if (accept) begin
        hk_nxt = in_key; hc_nxt = in_data.tuple_count;
        hb_start = 1'b1;
      end
      ST_HASHB: begin
        sa_nxt = hash_a(hk_r, n);
        if (hb_done) sb_nxt = hb_slot;
      end
      ST_RD1: addr = {1'b0, sa_r};
      ST_CMP1, ST_CMP2: begin
        addr = (st_r == ST_CMP1) ? {1'b0, sa_r} : {1'b1, sb_r};
        out_nxt = '0;
        out_nxt.count_out = cnt_r;
        if (v_rd && key_eq) begin
          out_nxt.hit = 1'b1;
          if (func_r == FUNC_PROBE) out_nxt.match_value = hit_r;
          else begin
            out_nxt.count_out = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            e_we = 1'b1;
            e_wd = {rd_key, out_nxt.count_out};
          end
        end else if (func_r == FUNC_PROBE) out_nxt.match_value = miss_r;
        first_nxt = 1'b1; kick_nxt = '0;
      end
      ST_RD2: addr = {1'b1, sb_r};
      ST_KHASH: begin
        sa_nxt = hash_a(hk_r, n);
        if (kick_r == KICK_W'(KICK_LIMIT)) out_nxt.status = 1'b1;
        else if (!first_r) hb_start = 1'b1;
      end
      ST_KHASHB: if (hb_done) sb_nxt = hb_slot;
      ST_KRD: addr = first_r ? {1'b0, sa_r} : {1'b1, sb_r};
      ST_KSWAP: begin
        addr = first_r ? {1'b0, sa_r} : {1'b1, sb_r};
        v_we = 1'b1; e_we = 1'b1;
        hk_nxt = rd_key; hc_nxt = rd_cnt;
        first_nxt = !first_r; kick_nxt = kick_r + 1'b1;
      end
      // hand the result over once the previous one has left
      ST_DONE: if (res_free) begin
        ovalid_nxt = 1'b1; res_nxt = out_r;
      end
      default: ;
    endcase
  end

  // the first lookup of a build in a kick starts at hash a with the new key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; ovalid_r <= ovalid_nxt;
    end
    if (accept) begin
      func_r <= in_data.func; cnt_r <= in_data.tuple_count;
    end
    hk_r <= hk_nxt; hc_r <= hc_nxt; first_r <= first_nxt; kick_r <= kick_nxt;
    sa_r <= sa_nxt; sb_r <= sb_nxt; out_r <= out_nxt; res_r <= res_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = res_r;
endmodule

[hw/rtl/chcp_checker.sv]
// port-level assertions for the cuckoo hash block and their binding
module chcp_checker import chcp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in flight");
  a_probe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.status && out_data.hit))
    else $error("dropped entry reported as hit");
  a_build: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.match_value == 32'd0)
    else $error("full build has match value");
endmodule

bind cuckoo_hash_count_and_probe chcp_checker u_chcp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
